// ----- rtl/gfp_pkg.sv -----
// Shared types and constants of the gamepad frame parser.
`default_nettype none

package gfp_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 16;
    localparam int POS_W       = 4;
    localparam int STORE_DEPTH = 12;
    localparam int STORE_IDX_W = 4;
    localparam int CFG_IDX_W   = 1;

    typedef logic [BYTE_W-1:0]        t_byte;
    typedef logic [WORD_W-1:0]        t_word;
    typedef logic signed [WORD_W-1:0] t_sword;
    typedef logic [POS_W-1:0]         t_pos;
    typedef logic [STORE_IDX_W-1:0]   t_store_idx;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;

    // CRC-16/CCITT-FALSE.
    localparam t_word CRC_INIT = 16'hFFFF;
    localparam t_word CRC_POLY = 16'h1021;
    localparam t_word CRC_TOP  = 16'h8000;

    // Frame byte positions.
    localparam t_pos POS_HUNT    = 4'd0;
    localparam t_pos POS_SYNC2   = 4'd1;
    localparam t_pos POS_PAYLOAD = 4'd2;
    localparam t_pos POS_COVER   = 4'd14;
    localparam t_pos POS_LAST    = 4'd15;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_SYNC_FIRST  = 1'b0;
    localparam t_cfg_idx CFG_SYNC_SECOND = 1'b1;

    localparam t_byte SYNC_FIRST_RST  = 8'hAA;
    localparam t_byte SYNC_SECOND_RST = 8'h55;

endpackage

`default_nettype wire

// ----- rtl/gfp_byte_if.sv -----
// Valid/ready channel that carries one received byte.
`default_nettype none

interface gfp_byte_if;
    import gfp_pkg::*;

    logic  valid;
    logic  ready;
    t_byte byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

`default_nettype wire

// ----- rtl/gfp_frame_if.sv -----
// Valid/ready channel that carries one decoded gamepad frame.
`default_nettype none

interface gfp_frame_if;
    import gfp_pkg::*;

    logic   valid;
    logic   ready;
    t_word  sequence_res;
    t_sword left_x;
    t_sword left_y;
    t_sword right_x;
    t_sword right_y;
    t_byte  button_bits;
    t_byte  flag_bits;

    modport source (
        output valid, output sequence_res, output left_x, output left_y,
        output right_x, output right_y, output button_bits, output flag_bits,
        input  ready
    );
    modport sink (
        input  valid, input sequence_res, input left_x, input left_y,
        input  right_x, input right_y, input button_bits, input flag_bits,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/gfp_crc_byte.sv -----
// Byte-wide unrolled CRC-16/CCITT-FALSE update, MSB first.
`default_nettype none

module gfp_crc_byte (
    input  wire gfp_pkg::t_word i_crc,
    input  wire gfp_pkg::t_byte i_data,
    output gfp_pkg::t_word      o_crc
);
    import gfp_pkg::*;

    always_comb begin
        t_word c;
        c = i_crc ^ {i_data, {(WORD_W-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++) begin
            if ((c & CRC_TOP) != '0) begin
                c = {c[WORD_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[WORD_W-2:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule

`default_nettype wire

// ----- rtl/gamepad_frame_parser_crc16.sv -----
// Top level of the gamepad frame parser with CRC-16 check.
`default_nettype none

// Gamepad frame parser. Received bytes enter one per transfer on i_byte; the
// block hunts for the two sync bytes (registers sync_first, index 0, and
// sync_second, index 1, reset 0xAA and 0x55), collects a 16-byte frame and
// checks CRC-16/CCITT-FALSE (init 0xFFFF, poly 0x1021, MSB first) over frame
// bytes 0 to 13 against the little-endian CRC in bytes 14 and 15. A frame
// that matches yields one transfer on o_frame in the cycle after its last byte;
// a frame that fails is dropped without any result, and hunting restarts at
// the byte after it. A wrong second sync byte that equals sync_first keeps
// the framer one byte into a new frame. The block takes one byte in every
// cycle: the CRC is updated a whole byte per cycle by an unrolled step. The
// input stalls only on the last byte of a frame, and only while a decoded
// frame still sits in the output register and the sink is not ready; every
// other byte is taken even then. Configuration is written through i_cfg_we,
// i_cfg_idx and i_cfg_data and should only change while the stream is idle.
module gamepad_frame_parser_crc16 (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_we,
    input  wire gfp_pkg::t_cfg_idx   i_cfg_idx,
    input  wire gfp_pkg::t_byte      i_cfg_data,
    gfp_byte_if.sink                 i_byte,
    gfp_frame_if.source              o_frame
);
    import gfp_pkg::*;

    // Configuration registers.
    t_byte r_sync_first;
    t_byte r_sync_second;

    // Framer state.
    t_pos  r_pos,  n_pos;
    t_word r_crc,  n_crc;
    t_byte r_crc_low;
    t_byte r_store [STORE_DEPTH];

    // Output register.
    logic   r_valid;
    t_word  r_sequence_res;
    t_sword r_left_x;
    t_sword r_left_y;
    t_sword r_right_x;
    t_sword r_right_y;
    t_byte  r_button_bits;
    t_byte  r_flag_bits;

    logic  in_fire;
    logic  frame_ok;
    t_byte b;
    t_word crc_seed;
    t_word crc_next;

    assign b       = i_byte.byte_in;
    // Only the last byte of a frame can produce a result, so only that byte
    // waits for the output register to be empty or to drain now.
    assign i_byte.ready = !r_valid || o_frame.ready || (r_pos != POS_LAST);
    assign in_fire = i_byte.valid && i_byte.ready;

    // The CRC restarts whenever a byte may open a new frame.
    assign crc_seed = ((r_pos == POS_HUNT) ||
                       ((r_pos == POS_SYNC2) && (b != r_sync_second))) ?
                      CRC_INIT : r_crc;

    gfp_crc_byte u_crc (
        .i_crc  (crc_seed),
        .i_data (b),
        .o_crc  (crc_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                CFG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next position and CRC for the accepted byte.
    always_comb begin
        n_pos    = r_pos;
        n_crc    = r_crc;
        frame_ok = 1'b0;
        if (in_fire) begin
            priority if (r_pos == POS_HUNT) begin
                if (b == r_sync_first) begin
                    n_crc = crc_next;
                    n_pos = POS_SYNC2;
                end
            end else if (r_pos == POS_SYNC2) begin
                // The second sync test wins when both sync bytes are equal.
                if (b == r_sync_second) begin
                    n_crc = crc_next;
                    n_pos = POS_PAYLOAD;
                end else if (b == r_sync_first) begin
                    n_crc = crc_next;
                    n_pos = POS_SYNC2;
                end else begin
                    n_crc = CRC_INIT;
                    n_pos = POS_HUNT;
                end
            end else if (r_pos < POS_COVER) begin
                n_crc = crc_next;
                n_pos = r_pos + 4'd1;
            end else if (r_pos == POS_COVER) begin
                n_pos = r_pos + 4'd1;
            end else begin
                // Last byte: compare and restart the hunt either way.
                frame_ok = ({b, r_crc_low} == r_crc);
                n_crc    = CRC_INIT;
                n_pos    = POS_HUNT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HUNT;
            r_crc <= CRC_INIT;
        end else begin
            r_pos <= n_pos;
            r_crc <= n_crc;
        end
    end

    // Payload bytes 2 to 13 and the low CRC byte need no reset: each frame
    // writes them all before they are read.
    always_ff @(posedge i_clk) begin
        if (in_fire && (r_pos >= POS_PAYLOAD) && (r_pos < POS_COVER)) begin
            r_store[t_store_idx'(r_pos - POS_PAYLOAD)] <= b;
        end
        if (in_fire && (r_pos == POS_COVER)) begin
            r_crc_low <= b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (frame_ok) begin
            r_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame_ok) begin
            r_sequence_res <= {r_store[1], r_store[0]};
            r_left_x       <= t_sword'({r_store[3], r_store[2]});
            r_left_y       <= t_sword'({r_store[5], r_store[4]});
            r_right_x      <= t_sword'({r_store[7], r_store[6]});
            r_right_y      <= t_sword'({r_store[9], r_store[8]});
            r_button_bits  <= r_store[10];
            r_flag_bits    <= r_store[11];
        end
    end

    assign o_frame.valid        = r_valid;
    assign o_frame.sequence_res = r_sequence_res;
    assign o_frame.left_x       = r_left_x;
    assign o_frame.left_y       = r_left_y;
    assign o_frame.right_x      = r_right_x;
    assign o_frame.right_y      = r_right_y;
    assign o_frame.button_bits  = r_button_bits;
    assign o_frame.flag_bits    = r_flag_bits;

    // A result only appears right after the last byte of a frame.
    a_result_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_frame.valid) |-> $past(in_fire && (r_pos == POS_LAST)))
        else $error("result without a completed frame");

    // The input only stalls behind a held result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_byte.ready |-> o_frame.valid)
        else $error("input stalled with empty output register");

    // While hunting, a byte other than sync_first leaves the framer hunting.
    a_hunt_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (r_pos == POS_HUNT) && (b != r_sync_first))
        |=> (r_pos == POS_HUNT) && (r_crc == CRC_INIT))
        else $error("framer left hunt without sync byte");

    // After the last byte the framer is always back to hunting.
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (r_pos == POS_LAST)) |=> (r_pos == POS_HUNT))
        else $error("framer did not restart after a frame");

endmodule

`default_nettype wire
